### sv/fbs_pkg.sv
package fbs_pkg;

  localparam int unsigned FRAME_WIDTH  = 240;
  localparam int unsigned FRAME_HEIGHT = 160;
  localparam int unsigned STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);

  localparam logic [15:0] BLEND_MASK  = 16'h0821;
  localparam logic [15:0] CLEAR_VALUE = 16'hFFFF;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
  } store_req_t;

  typedef struct packed {
    logic [15:0] idx;
    logic [15:0] pix;
    logic [15:0] prev;
    logic        mix;
  } pix_item_t;

  function automatic logic [15:0] blend_half(logic [15:0] a, logic [15:0] b);
    logic [17:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, (a ^ b) & BLEND_MASK};
    return s[16:1];
  endfunction

  function automatic logic [15:0] swap_order(logic [15:0] p);
    return {1'b0, p[4:0], p[10:6], p[15:11]};
  endfunction

endpackage

### sv/rgb565_frame_blend_swap.sv
// rgb565_frame_blend_swap: blends an RGB565 pixel stream with the previous
// frame (when mix_enable is set) and re-packs it to xBBBBBGGGGGRRRRR order.
// Input stream: s_axis, tdata = {pixel_in, pixel_index}, tuser = opcode
// (pixel item or clear). Output stream: m_axis, tdata = {lcd_pixel,
// pixel_index_out}. A one-bit config channel sets mix_enable and is always
// ready; write it only while the block is idle.
// Throughput is one pixel per cycle while m_axis_tready is high and no
// refill runs. A pixel passes three register stages on its way to m_axis
// (frame store read, blend, swap/output register). The frame store read
// and its write of the new pixel happen in the same cycle on one read-first
// port, so pixels at the same position may follow back to back.
// After reset and after each clear item the store is refilled with 0xFFFF,
// one word a cycle over all STORE_DEPTH entries (38400 at 240x160);
// s_axis_tready stays low meanwhile. A clear item gives no output pixel.
// When m_axis_tready is low the stages fill up and s_axis_tready drops;
// nothing is lost or repeated.
module rgb565_frame_blend_swap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_index, pixel_in
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_index_out, lcd_pixel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import fbs_pkg::*;

  logic              mix_en_q;
  logic              sweep_q, sweep_d;
  logic [ADDR_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic              s1_valid_q, s1_valid_d;
  logic [15:0]       s1_idx_q, s1_pix_q;
  logic              s1_mix_q;
  logic              s1_ready, accept, is_clear, is_pixel, in_range, use_mem;
  logic [15:0]       in_idx, in_pix, prev;
  logic [15:0]       out_idx, out_lcd;
  store_req_t        store_req;
  pix_item_t         s1_item;
  logic              sweep_last;

  assign in_idx   = s_axis_tdata[15:0];
  assign in_pix   = s_axis_tdata[31:16];
  assign is_clear = (opcode_e'(s_axis_tuser) == OP_CLEAR);
  assign is_pixel = !is_clear;
  assign in_range = (32'(in_idx) < STORE_DEPTH);

  assign s_axis_tready = !sweep_q && s1_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign use_mem       = mix_en_q && in_range;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mix_en_q <= cfg_data_i;
    end
  end

  // refill sweep
  assign sweep_last = (sweep_cnt_q == ADDR_W'(STORE_DEPTH - 1));

  always_comb begin
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    if (sweep_q) begin
      sweep_cnt_d = sweep_cnt_q + ADDR_W'(1);
      if (sweep_last) begin
        sweep_d     = 1'b0;
        sweep_cnt_d = '0;
      end
    end else if (accept && is_clear) begin
      sweep_d     = 1'b1;
      sweep_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
    end else begin
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  always_comb begin
    store_req = '0;
    if (sweep_q) begin
      store_req.we    = 1'b1;
      store_req.addr  = sweep_cnt_q;
      store_req.wdata = CLEAR_VALUE;
    end else begin
      store_req.we    = accept && is_pixel && use_mem;
      store_req.re    = accept && is_pixel && use_mem;
      store_req.addr  = ADDR_W'(in_idx);
      store_req.wdata = in_pix;
    end
  end

  fbs_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (prev)
  );

  // stage 1: store read in flight
  assign s1_valid_d = s1_ready ? (accept && is_pixel) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_pixel) begin
      s1_idx_q <= in_idx;
      s1_pix_q <= in_pix;
      s1_mix_q <= use_mem;
    end
  end

  assign s1_item = '{idx: s1_idx_q, pix: s1_pix_q, prev: prev, mix: s1_mix_q};

  fbs_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ready_o (s1_ready),
    .item_i  (s1_item),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .idx_o   (out_idx),
    .lcd_o   (out_lcd)
  );

  assign m_axis_tdata = {out_lcd, out_idx};

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !s_axis_tready)
    else $error("item accepted during store refill");

  a_clear_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_clear) |=> (sweep_q && sweep_cnt_q == '0))
    else $error("clear item did not start refill");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sweep_q && sweep_last) |=> !sweep_q)
    else $error("refill did not end at last entry");

  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.we |-> (sweep_q || (accept && is_pixel && mix_en_q)))
    else $error("unexpected frame store write");

endmodule

### sv/fbs_store.sv
module fbs_store (
  input  logic               clk_i,
  input  fbs_pkg::store_req_t req_i,
  output logic [15:0]        rdata_o
);
  import fbs_pkg::*;

  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rdata_q;

  // read-first: a read and a write at one address return the old word
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/fbs_blend.sv
module fbs_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  fbs_pkg::pix_item_t  item_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [15:0]         idx_o,
  output logic [15:0]         lcd_o
);
  import fbs_pkg::*;

  logic        s2_valid_q, s2_valid_d;
  logic [15:0] s2_idx_q, s2_val_q;
  logic        s3_valid_q, s3_valid_d;
  logic [15:0] s3_idx_q, s3_lcd_q;
  logic        s2_ready, s3_ready;

  assign s3_ready = !s3_valid_q || ready_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign ready_o  = s2_ready;

  assign s2_valid_d = s2_ready ? valid_i : s2_valid_q;
  assign s3_valid_d = s3_ready ? s2_valid_q : s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      s3_valid_q <= s3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && valid_i) begin
      s2_idx_q <= item_i.idx;
      s2_val_q <= item_i.mix ? blend_half(item_i.pix, item_i.prev) : item_i.pix;
    end
    if (s3_ready && s2_valid_q) begin
      s3_idx_q <= s2_idx_q;
      s3_lcd_q <= swap_order(s2_val_q);
    end
  end

  assign valid_o = s3_valid_q;
  assign idx_o   = s3_idx_q;
  assign lcd_o   = s3_lcd_q;

endmodule
